// ===== rtl/rlim_pkg.sv =====
// ----------------------------------------------------------------------------
// rlim_pkg
// Shared types and constants of the per-user fixed-window rate limiter.
// ----------------------------------------------------------------------------
package rlim_pkg;

   localparam int RLIM_USER_SLOTS = 1024;

   localparam int ACTION_W  = 2;
   localparam int USER_ID_W = 10;
   localparam int TIME_W    = 40;
   localparam int COUNT_W   = 16;
   localparam int COOL_W    = 32;

   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 32;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_COOLDOWN = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_QUOTA    = 8'd1;

   // reset values
   localparam logic [COOL_W-1:0]  COOLDOWN_RESET = 32'd60;
   localparam logic [COUNT_W-1:0] QUOTA_RESET    = 16'd1;

   // actions
   localparam logic [ACTION_W-1:0] ACT_QUERY   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_CONSUME = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_RESET   = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_ENROLL  = 2'd3;

   localparam logic [TIME_W-1:0] SECS_TOP = 40'hFF_FFFF_FFFF;

   typedef struct packed {
      logic [ACTION_W-1:0]  action;
      logic [USER_ID_W-1:0] user_id;
      logic [TIME_W-1:0]    now_seconds;
   } req_payload_type;

   typedef struct packed {
      logic                ok;
      logic                found;
      logic [COUNT_W-1:0]  remaining_placements;
      logic [TIME_W-1:0]   remaining_seconds;
   } rsp_payload_type;

   typedef struct packed {
      logic               valid;
      logic [TIME_W-1:0]  window_start;
      logic [COUNT_W-1:0] placed_count;
   } slot_entry_type;

endpackage

// ===== rtl/per_user_fixed_window_rate_limiter_core.sv =====
// ----------------------------------------------------------------------------
// per_user_fixed_window_rate_limiter_core
// Per-slot fixed-window placement quota with query, consume, reset and enroll.
// ----------------------------------------------------------------------------
// On the accept edge the block registers a read of the slot's entry from the
// slot memory; in the calculate state the block writes the updated entry back
// and loads the result register. One request is in flight at a time, so a
// write always lands before the next read and no forwarding is needed; a new
// request is not accepted until the last one has left the calculate state. A
// finished result waits in its output register while the next request is
// accepted; that request holds in the calculate state until the result
// register frees. After reset the block sweeps the slot memory, one entry a
// cycle, to clear every valid mark: during the sweep no request is accepted,
// while configuration writes are taken at all times.
module per_user_fixed_window_rate_limiter_core
   import rlim_pkg::*;
#(
   parameter int USER_SLOTS = RLIM_USER_SLOTS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_payload_type        req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_payload_type        rsp_payload,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int IDX_W = $clog2(USER_SLOTS);
   localparam int DIFF_W = TIME_W + 3;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_CALC  = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [IDX_W-1:0]   clr_idx_ff, clr_idx_in;
   logic [COOL_W-1:0]  cooldown_ff, cooldown_in;
   logic [COUNT_W-1:0] quota_ff, quota_in;
   req_payload_type    req_ff;
   slot_entry_type     rd_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_ff, rsp_in;

   slot_entry_type     slot_mem [USER_SLOTS];

   logic               req_fire;
   logic               calc_done;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   slot_entry_type     mem_wdata;
   logic [IDX_W-1:0]   req_idx;
   logic [IDX_W-1:0]   cur_idx;
   logic               in_range;
   logic               known;
   logic               wr_slot;
   slot_entry_type     new_entry;
   logic [DIFF_W-1:0]  diff;
   logic               window_open;
   logic [TIME_W-1:0]  diff_sat;
   logic [COUNT_W-1:0] cnt_base;
   logic [TIME_W-1:0]  secs_base;
   logic [COUNT_W-1:0] cnt_next;
   logic [COUNT_W-1:0] left_query;
   logic [COUNT_W-1:0] left_consume;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign req_idx = IDX_W'(req_payload.user_id);
   assign cur_idx = IDX_W'(req_ff.user_id);

   // configuration registers
   always_comb begin
      cooldown_in = cooldown_ff;
      quota_in    = quota_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_COOLDOWN: cooldown_in = csr_data;
            CSR_QUOTA:    quota_in    = csr_data[COUNT_W-1:0];
            default:      ;
         endcase
      end
   end

   // window arithmetic: diff = cooldown - elapsed = cooldown + start - now
   assign diff = DIFF_W'(cooldown_ff) + DIFF_W'(rd_ff.window_start)
                 - DIFF_W'(req_ff.now_seconds);
   assign window_open = (rd_ff.window_start != '0) && !diff[DIFF_W-1] && (diff != '0);
   assign diff_sat = (diff[DIFF_W-2:TIME_W] != '0) ? SECS_TOP : diff[TIME_W-1:0];

   assign in_range = 32'(req_ff.user_id) < 32'(USER_SLOTS);
   assign known    = in_range && (rd_ff.valid || req_ff.action == ACT_ENROLL);

   assign cnt_base  = window_open ? rd_ff.placed_count : '0;
   assign secs_base = window_open ? diff_sat : TIME_W'(cooldown_ff);
   assign cnt_next  = cnt_base + 16'd1;
   assign left_query = (rd_ff.placed_count >= quota_ff) ? '0 : quota_ff - rd_ff.placed_count;
   assign left_consume = quota_ff - cnt_next;

   always_comb begin
      wr_slot   = 1'b0;
      new_entry = '{valid: 1'b1, window_start: '0, placed_count: '0};
      rsp_in    = '{ok: 1'b0, found: 1'b0, remaining_placements: '0,
                    remaining_seconds: TIME_W'(cooldown_ff)};
      if (known) begin
         case (req_ff.action)
            ACT_ENROLL: begin
               wr_slot = 1'b1;
               rsp_in  = '{ok: 1'b1, found: rd_ff.valid, remaining_placements: quota_ff,
                           remaining_seconds: '0};
            end
            ACT_RESET: begin
               wr_slot = 1'b1;
               rsp_in  = '{ok: 1'b1, found: 1'b1, remaining_placements: quota_ff,
                           remaining_seconds: '0};
            end
            ACT_QUERY: begin
               if (!window_open) begin
                  rsp_in = '{ok: 1'b0, found: 1'b1, remaining_placements: quota_ff,
                             remaining_seconds: '0};
               end else begin
                  rsp_in = '{ok: 1'b0, found: 1'b1, remaining_placements: left_query,
                             remaining_seconds: (left_query != '0) ? '0 : diff_sat};
               end
            end
            ACT_CONSUME: begin
               // restart an expired window before the quota check
               wr_slot = 1'b1;
               new_entry.window_start = window_open ? rd_ff.window_start
                                                    : req_ff.now_seconds;
               if (cnt_base >= quota_ff) begin
                  new_entry.placed_count = cnt_base;
                  rsp_in = '{ok: 1'b0, found: 1'b1, remaining_placements: '0,
                             remaining_seconds: secs_base};
               end else begin
                  new_entry.placed_count = cnt_next;
                  rsp_in = '{ok: 1'b1, found: 1'b1, remaining_placements: left_consume,
                             remaining_seconds: (left_consume != '0) ? '0 : secs_base};
               end
            end
            default: ;
         endcase
      end
   end

   assign calc_done = (state_ff == ST_CALC) && (!rsp_valid_ff || rsp_ready);

   // control
   always_comb begin
      state_in     = state_ff;
      clr_idx_in   = clr_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_CLEAR: begin
            clr_idx_in = clr_idx_ff + 1'b1;
            if (clr_idx_ff == IDX_W'(USER_SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            if (calc_done) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // memory write port: clearing sweep or write-back
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = cur_idx;
      mem_wdata = new_entry;
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_idx_ff;
         mem_wdata = '0;
      end else if (calc_done && wr_slot) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      if (req_fire) begin
         rd_ff <= slot_mem[req_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_ff <= req_payload;
      end
      if (calc_done) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         cooldown_ff  <= COOLDOWN_RESET;
         quota_ff     <= QUOTA_RESET;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         rsp_valid_ff <= rsp_valid_in;
         cooldown_ff  <= cooldown_in;
         quota_ff     <= quota_in;
      end
   end

endmodule
